### sv/cor_pkg.sv
// Package for the circle outline rasterizer: widths, operation codes and the
// point-set record passed from the decision core to the point emitter.
// Depends on nothing.
`default_nettype none

package cor_pkg;

    // Radius width of the internal datapath (valid range 4 to 16).
    localparam int RADIUS_BITS = 10;

    // Fixed widths of the interface fields.
    localparam int CENTER_W = 11;
    localparam int RIN_W    = 10;
    localparam int COORD_W  = 13;

    // Signed width of the decision variable and its temporaries.
    localparam int DEC_W = RADIUS_BITS + 3;

    // Width used when folding an offset into a coordinate.
    localparam int EXT_W = (RADIUS_BITS > COORD_W) ? RADIUS_BITS : COORD_W;

    // Width used when narrowing the incoming radius.
    localparam int RWIDE_W = (RADIUS_BITS > RIN_W) ? RADIUS_BITS : RIN_W;

    // Eight mirrored points per step.
    localparam int POINTS_PER_STEP = 8;
    localparam int IDX_W           = $clog2(POINTS_PER_STEP);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS_PER_STEP - 1);

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // One step's worth of points: centre, offset pair and end-of-shape flag.
    typedef struct packed {
        logic [CENTER_W-1:0]    cx;
        logic [CENTER_W-1:0]    cy;
        logic [RADIUS_BITS-1:0] ox;
        logic [RADIUS_BITS-1:0] oy;
        logic                   last;
    } point_set_t;

endpackage

`default_nettype wire

### sv/cor_core.sv
// Decision core: holds the circle state and runs one decision-rule iteration
// per accepted step request while a shape is active. Depends on cor_pkg.
`default_nettype none

module cor_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic                         operation,
    input  wire logic [cor_pkg::CENTER_W-1:0] center_x,
    input  wire logic [cor_pkg::CENTER_W-1:0] center_y,
    input  wire logic [cor_pkg::RIN_W-1:0]    radius,
    input  wire logic                         filled,
    output logic                              set_load,
    output cor_pkg::point_set_t               set_data
);

    localparam int RB = cor_pkg::RADIUS_BITS;
    localparam int DW = cor_pkg::DEC_W;
    localparam logic signed [DW-1:0] ONE_S = DW'(1);

    logic [cor_pkg::CENTER_W-1:0] cx_reg, cx_next;
    logic [cor_pkg::CENTER_W-1:0] cy_reg, cy_next;
    logic [RB-1:0]                target_r_reg, target_r_next;
    logic [RB-1:0]                current_r_reg, current_r_next;
    logic [RB-1:0]                off_x_reg, off_x_next;
    logic [RB-1:0]                off_y_reg, off_y_next;
    logic signed [DW-1:0]         decision_reg, decision_next;
    logic                         fill_mode_reg, fill_mode_next;
    logic                         active_reg, active_next;

    logic [cor_pkg::RWIDE_W-1:0] r_wide;
    logic [RB-1:0]               r_in;
    logic [RB-1:0]               start_r;
    logic [RB-1:0]               grow_r;
    logic signed [DW-1:0]        ox_s, oy_s, cr_s;
    logic signed [DW-1:0]        nx_s, ny_s, dec_s;
    logic                        finish;
    logic                        grow;

    assign r_wide  = cor_pkg::RWIDE_W'(radius);
    assign r_in    = r_wide[RB-1:0];
    assign start_r = filled ? '0 : r_in;
    assign grow_r  = current_r_reg + RB'(1);

    assign ox_s = $signed(DW'(off_x_reg));
    assign oy_s = $signed(DW'(off_y_reg));
    assign cr_s = $signed(DW'(current_r_reg));

    // One iteration of the Andres rule on the current offset pair.
    always_comb begin
        nx_s  = ox_s;
        ny_s  = oy_s;
        dec_s = decision_reg;
        if (decision_reg >= (ox_s <<< 1)) begin
            dec_s = decision_reg - (ox_s <<< 1) - ONE_S;
            nx_s  = ox_s + ONE_S;
        end else if (decision_reg < ((cr_s - oy_s) <<< 1)) begin
            dec_s = decision_reg + (oy_s <<< 1) - ONE_S;
            ny_s  = oy_s - ONE_S;
        end else begin
            dec_s = decision_reg + ((oy_s - ox_s - ONE_S) <<< 1);
            ny_s  = oy_s - ONE_S;
            nx_s  = ox_s + ONE_S;
        end
    end

    assign finish = (ny_s < nx_s);
    assign grow   = fill_mode_reg && (current_r_reg < target_r_reg);

    assign set_load      = accept && (operation == cor_pkg::OP_STEP) && active_reg;
    assign set_data.cx   = cx_reg;
    assign set_data.cy   = cy_reg;
    assign set_data.ox   = off_x_reg;
    assign set_data.oy   = off_y_reg;
    assign set_data.last = finish && !grow;

    always_comb begin
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        target_r_next  = target_r_reg;
        current_r_next = current_r_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        decision_next  = decision_reg;
        fill_mode_next = fill_mode_reg;
        active_next    = active_reg;
        if (accept && (operation == cor_pkg::OP_START)) begin
            cx_next        = center_x;
            cy_next        = center_y;
            target_r_next  = r_in;
            fill_mode_next = filled;
            active_next    = 1'b1;
            current_r_next = start_r;
            off_x_next     = '0;
            off_y_next     = start_r;
            decision_next  = $signed(DW'(start_r)) - ONE_S;
        end else if (set_load) begin
            if (!finish) begin
                off_x_next    = nx_s[RB-1:0];
                off_y_next    = ny_s[RB-1:0];
                decision_next = dec_s;
            end else if (grow) begin
                // Move out to the next concentric circle.
                current_r_next = grow_r;
                off_x_next     = '0;
                off_y_next     = grow_r;
                decision_next  = $signed(DW'(grow_r)) - ONE_S;
            end else begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            target_r_reg  <= '0;
            current_r_reg <= '0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            decision_reg  <= '0;
            fill_mode_reg <= 1'b0;
            active_reg    <= 1'b0;
        end else begin
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            target_r_reg  <= target_r_next;
            current_r_reg <= current_r_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            decision_reg  <= decision_next;
            fill_mode_reg <= fill_mode_next;
            active_reg    <= active_next;
        end
    end

endmodule

`default_nettype wire

### sv/cor_emit.sv
// Point emitter: holds one step's point set and sends its eight mirrored points
// one per cycle while the result channel is ready. Depends on cor_pkg.
`default_nettype none

module cor_emit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               set_load,
    input  wire cor_pkg::point_set_t                set_data,
    output logic                                    set_free,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [cor_pkg::COORD_W-1:0]      m_point_x,
    output logic signed [cor_pkg::COORD_W-1:0]      m_point_y,
    output logic                                    m_last
);

    localparam int CW = cor_pkg::COORD_W;
    localparam int EW = cor_pkg::EXT_W;

    cor_pkg::point_set_t         set_reg;
    logic                        busy_reg;
    logic [cor_pkg::IDX_W-1:0]   idx_reg;

    logic                        take;
    logic [cor_pkg::RADIUS_BITS-1:0] off_a, off_b;
    logic [EW-1:0]               a_ext, b_ext;
    logic [CW-1:0]               a_c, b_c, dx, dy;

    assign take     = busy_reg && m_ready;
    assign set_free = !busy_reg || (take && (idx_reg == cor_pkg::IDX_LAST));

    // Index bit 0 swaps the pair, bit 1 negates x, bit 2 negates y.
    assign off_a = idx_reg[0] ? set_reg.oy : set_reg.ox;
    assign off_b = idx_reg[0] ? set_reg.ox : set_reg.oy;
    assign a_ext = EW'(off_a);
    assign b_ext = EW'(off_b);
    assign a_c   = a_ext[CW-1:0];
    assign b_c   = b_ext[CW-1:0];
    assign dx    = idx_reg[1] ? (CW'(0) - a_c) : a_c;
    assign dy    = idx_reg[2] ? (CW'(0) - b_c) : b_c;

    assign m_valid   = busy_reg;
    assign m_point_x = $signed(CW'(set_reg.cx) + dx);
    assign m_point_y = $signed(CW'(set_reg.cy) + dy);
    assign m_last    = set_reg.last && (idx_reg == cor_pkg::IDX_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (set_load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take) begin
            if (idx_reg == cor_pkg::IDX_LAST) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + cor_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (set_load) begin
            set_reg <= set_data;
        end
    end

endmodule

`default_nettype wire

### sv/circle_outline_rasterizer.sv
// Top level of the circle outline rasterizer: Andres decision core feeding an
// eight-point emitter. Depends on cor_pkg, cor_core and cor_emit.
//
//   channel | direction | ports                                           | meaning
//   s_      | in        | valid, ready, operation, center_x/y, radius,    | start or step request
//           |           | filled                                          |
//   m_      | out       | valid, ready, point_x, point_y, last            | one pixel per transfer
//
// An accepted step request, while a shape is active, updates the decision
// core at the accepting edge and hands the eight-point set to the emitter register.
// The emitter sends one point per cycle while m_ready is high; the next
// request is accepted in the cycle the eighth point leaves, and any request
// is accepted whenever the emitter is idle.
// Reset (aresetn, synchronous, active low) returns the block to idle with no
// point pending. A stalled result channel holds the current point and holds
// off new requests while the point set is still in use.
`default_nettype none

module circle_outline_rasterizer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_operation,
    input  wire logic [cor_pkg::CENTER_W-1:0]        s_center_x,
    input  wire logic [cor_pkg::CENTER_W-1:0]        s_center_y,
    input  wire logic [cor_pkg::RIN_W-1:0]           s_radius,
    input  wire logic                                s_filled,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [cor_pkg::COORD_W-1:0]       m_point_x,
    output logic signed [cor_pkg::COORD_W-1:0]       m_point_y,
    output logic                                     m_last
);

    // A request is taken whenever the emitter can accept a new point set,
    // which covers both an empty emitter and one sending its eighth point.
    logic                accept;
    logic                set_load;
    logic                set_free;
    cor_pkg::point_set_t set_data;

    assign s_ready = set_free;
    assign accept  = s_valid && s_ready;

    // The core owns the centre, radii, offset pair and decision variable.
    cor_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .operation (s_operation),
        .center_x  (s_center_x),
        .center_y  (s_center_y),
        .radius    (s_radius),
        .filled    (s_filled),
        .set_load  (set_load),
        .set_data  (set_data)
    );

    // The emitter mirrors the offset pair into the eight octants in order.
    cor_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .set_load  (set_load),
        .set_data  (set_data),
        .set_free  (set_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y),
        .m_last    (m_last)
    );

endmodule

`default_nettype wire

### sv/cor_checker.sv
// Port-level checks for the circle outline rasterizer, bound to the top level.
// Depends on cor_pkg and circle_outline_rasterizer.
`default_nettype none

module cor_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [cor_pkg::COORD_W-1:0]  m_point_x,
    input wire logic signed [cor_pkg::COORD_W-1:0]  m_point_y,
    input wire logic                                m_last
);

    // A stalled point stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y)
            && $stable(m_last))
        else $error("stalled result changed");

    // Nothing is pending right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With no point pending the block takes requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("idle block refused a request");

    // The final point of a shape frees the emitter in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |-> s_ready)
        else $error("last point did not free the emitter");

endmodule

bind circle_outline_rasterizer cor_checker u_cor_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y),
    .m_last    (m_last)
);

`default_nettype wire
